@@ rtl/swm_pkg.sv @@
// shared types and constants for the sliding window maximum block
// no dependencies; imported by swm_cell and sliding_window_maximum_top
package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int W_SAMPLE   = 32;
    localparam int W_POS      = 32;
    localparam int W_LEN      = 7;
    localparam logic [W_LEN-1:0] LEN_RESET = 7'd3;

    typedef logic signed [W_SAMPLE-1:0] t_sample;
    typedef logic [W_POS-1:0]           t_pos;

    // per-item control broadcast to every cell of the chain
    typedef struct packed {
        logic    step;
        logic    shift;
        logic    first;
        t_sample sample;
        t_pos    pos;
    } t_step_ctl;

endpackage

@@ rtl/sliding_window_maximum_top.sv @@
// sliding window maximum: monotonic candidate store as a chain of swm_cell
// depends on swm_pkg and swm_cell
//
//  channel  dir  handshake                  payload
//  s_*      in   s_tvalid / s_tready        tdata[31:0] sample, tuser[0] first_sample
//  m_*      out  m_tvalid / m_tready        tdata[31:0] window_max, [63:32] window_number
//  cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_data[6:0] window_len
//
// one item per cycle while s_tready is high: all cells compare against the new
// sample in parallel and shift by at most one slot, so an item finishes in the
// cycle it is accepted. a result shows on m_* in the cycle after its item; s_tready
// follows m_tready while a result is held. reset is synchronous, active low, and
// clears the occupied flags, the position and window counters; window_len resets to 3.
module sliding_window_maximum_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample
    input  logic [0:0]  s_tuser,   // first_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // window_max, window_number
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data // window_len
);
    import swm_pkg::*;

    logic [W_LEN-1:0] r_len;
    t_pos             r_pos;
    t_pos             r_windows;
    logic             r_out_valid;
    t_sample          r_out_max;
    t_pos             r_out_num;

    logic             s_accept;
    logic [31:0]      len32;
    logic [31:0]      k32;
    t_pos             pos;
    t_pos             win;
    logic             drop_old;
    logic             emit;
    t_step_ctl        ctl;

    logic    c_keep       [WINDOW_MAX+1];
    logic    c_valid      [WINDOW_MAX];
    t_sample c_value      [WINDOW_MAX+1];
    t_pos    c_pos        [WINDOW_MAX+1];
    t_sample c_next_value [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] valid_vec;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = !r_out_valid || m_tready;
    assign s_accept    = s_tvalid && s_tready;

    always_comb begin
        len32 = {{(32-W_LEN){1'b0}}, r_len};
        if (len32 == 32'd0) begin
            k32 = 32'd1;
        end else if (len32 > 32'(WINDOW_MAX)) begin
            k32 = 32'(WINDOW_MAX);
        end else begin
            k32 = len32;
        end
        pos      = s_tuser[0] ? '0 : r_pos;
        win      = s_tuser[0] ? '0 : r_windows;
        // oldest candidate ages out, modular age
        drop_old = c_valid[0] && !s_tuser[0] && ((pos - c_pos[0]) >= k32);
        emit     = (pos >= (k32 - 32'd1)) || (win != '0);
        ctl.step   = s_accept;
        // keep in the last cell means the store would overflow
        ctl.shift  = drop_old || c_keep[WINDOW_MAX-1];
        ctl.first  = s_tuser[0];
        ctl.sample = t_sample'(s_tdata);
        ctl.pos    = pos;
    end

    assign c_keep[WINDOW_MAX]  = 1'b0;
    assign c_value[WINDOW_MAX] = '0;
    assign c_pos[WINDOW_MAX]   = '0;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic below_keep;
        if (g == 0) begin : g_head
            assign below_keep = 1'b1;
        end else begin : g_body
            assign below_keep = c_keep[g-1];
        end
        swm_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_head        (1'(g == 0)),
            .i_above_keep  (c_keep[g+1]),
            .i_above_value (c_value[g+1]),
            .i_above_pos   (c_pos[g+1]),
            .i_below_keep  (below_keep),
            .o_keep        (c_keep[g]),
            .o_valid       (c_valid[g]),
            .o_value       (c_value[g]),
            .o_pos         (c_pos[g]),
            .o_next_value  (c_next_value[g])
        );
        assign valid_vec[g] = c_valid[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RESET;
            r_pos       <= '0;
            r_windows   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
            if (s_accept) begin
                r_pos       <= pos + 32'd1;
                r_windows   <= emit ? win + 32'd1 : win;
                r_out_valid <= emit;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s_accept) begin
            r_out_max <= c_next_value[0];
            r_out_num <= win;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out_num, r_out_max};

`ifndef NO_ASSERTIONS
    // occupied cells always form a prefix of the chain
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("store occupancy is not a prefix");

    // after any item the store holds at least the new candidate
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> c_valid[0])
        else $error("store empty after an item");

    // a first-marked item leaves exactly one candidate
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_tuser[0]) |=> ($countones(valid_vec) == 1))
        else $error("first item did not clear the store");

    // a result appears exactly when the item emits
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (m_tvalid == $past(emit)))
        else $error("result presence does not match emit");
`endif

endmodule

@@ rtl/swm_cell.sv @@
// one candidate slot of the monotonic store: value, position and occupied flag
// depends on swm_pkg; its neighbors in the chain are wired by the top level
module swm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swm_pkg::t_step_ctl i_ctl,
    input  logic               i_head,
    input  logic               i_above_keep,
    input  swm_pkg::t_sample   i_above_value,
    input  swm_pkg::t_pos      i_above_pos,
    input  logic               i_below_keep,
    output logic               o_keep,
    output logic               o_valid,
    output swm_pkg::t_sample   o_value,
    output swm_pkg::t_pos      o_pos,
    output swm_pkg::t_sample   o_next_value
);
    import swm_pkg::*;

    logic    r_valid;
    t_sample r_value;
    t_pos    r_pos;
    logic    n_valid;
    t_sample n_value;
    t_pos    n_pos;
    logic    src_keep;
    logic    lower_keep;

    // survives the pop: older than the new item and strictly larger
    assign o_keep = r_valid && !i_ctl.first && (r_value > i_ctl.sample);

    always_comb begin
        src_keep   = i_ctl.shift ? i_above_keep : o_keep;
        lower_keep = i_head || (i_ctl.shift ? o_keep : i_below_keep);
        n_valid    = 1'b0;
        n_value    = r_value;
        n_pos      = r_pos;
        if (src_keep) begin
            n_valid = 1'b1;
            n_value = i_ctl.shift ? i_above_value : r_value;
            n_pos   = i_ctl.shift ? i_above_pos : r_pos;
        end else if (lower_keep) begin
            // first free slot after the kept prefix takes the new item
            n_valid = 1'b1;
            n_value = i_ctl.sample;
            n_pos   = i_ctl.pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.step) begin
            r_valid <= n_valid;
        end
        if (i_ctl.step) begin
            r_value <= n_value;
            r_pos   <= n_pos;
        end
    end

    assign o_valid      = r_valid;
    assign o_value      = r_value;
    assign o_pos        = r_pos;
    assign o_next_value = n_value;

endmodule
